/* rtl/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// shared constants, types and tables of the swept formant resonator
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 25;

  localparam logic [CFG_IDX_W-1:0] REG_START_FREQ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_RESON  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_FREQ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RESON = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_RATE   = 3'd6;

  localparam logic [15:0] GAIN_ONE   = 16'd16384;
  localparam logic [24:0] RATE_RESET = 25'd33554;
  localparam logic [24:0] ONE_Q24    = 25'd16777216;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  // cordic sequencer request and response
  typedef struct packed {
    logic        start;
    logic [15:0] freq;
  } sfr_cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] cos_val;
  } sfr_cordic_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_INTERP,
    ST_COS_GO,
    ST_COS_WAIT,
    ST_A1,
    ST_A2,
    ST_ACC_G,
    ST_ACC_1,
    ST_ACC_2,
    ST_OUT
  } sfr_state_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/swept_formant_resonator_top.sv */
// ----------------------------------------------------------------------------
// swept_formant_resonator_top
// two-pole resonator with linear sweep of frequency, radius and gain
// ----------------------------------------------------------------------------
// channel  dir  fields (lsb first)
// in_      in   tdata: sample; tuser: set_start, start_sweep
// out_     out  tdata: filtered; tuser: clipped, sweeping
// cfg_     in   index 0..6, data up to 25 bits
//
// when coefficients are recomputed (set_start or a sweep step), the result
// beat also waits for the cordic loop
// in_tready is low from acceptance until the result beat is taken; the next
// input beat can be accepted in the cycle after the result beat is taken
// reset is synchronous, active low, and clears all filter and sweep state
// ----------------------------------------------------------------------------
module swept_formant_resonator_top #(
  parameter int SAMPLE_BITS  = sfr_pkg::SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = sfr_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,  // sample
  input  logic [1:0]                       in_tuser,  // set_start, start_sweep
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata, // filtered
  output logic [1:0]                       out_tuser, // clipped, sweeping
  input  logic                             cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // config registers
  logic [15:0] start_freq_r, start_reson_r, start_gain_r;
  logic [15:0] target_freq_r, target_reson_r, target_gain_r;
  logic [24:0] sweep_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_freq_r   <= '0;
      start_reson_r  <= '0;
      start_gain_r   <= sfr_pkg::GAIN_ONE;
      target_freq_r  <= '0;
      target_reson_r <= '0;
      target_gain_r  <= sfr_pkg::GAIN_ONE;
      sweep_rate_r   <= sfr_pkg::RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::REG_START_FREQ:   start_freq_r   <= cfg_data[15:0];
        sfr_pkg::REG_START_RESON:  start_reson_r  <= cfg_data[15:0];
        sfr_pkg::REG_START_GAIN:   start_gain_r   <= cfg_data[15:0];
        sfr_pkg::REG_TARGET_FREQ:  target_freq_r  <= cfg_data[15:0];
        sfr_pkg::REG_TARGET_RESON: target_reson_r <= cfg_data[15:0];
        sfr_pkg::REG_TARGET_GAIN:  target_gain_r  <= cfg_data[15:0];
        sfr_pkg::REG_SWEEP_RATE:   sweep_rate_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // filter and sweep state
  sfr_pkg::sfr_state_t state_r, state_nxt;
  logic signed [39:0] y1_r, y2_r;
  logic [15:0]        base_f_r, base_r_r, cur_f_r, cur_r_r;
  logic signed [15:0] base_g_r, cur_g_r;
  logic signed [17:0] d_f_r, d_r_r, d_g_r;
  logic [24:0]        pos_r;
  logic               active_r;
  logic signed [17:0] a1_r, a2_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic               upd_r;
  logic [1:0]         isel_r;
  logic signed [74:0] acc_r;
  logic [31:0]        out_data_r;
  logic               clip_r, out_valid_r;

  // flags of the accepted beat and sweep interpolation enable
  logic [1:0]         in_tuser_hold_r;
  logic               interp_r;

  sfr_pkg::sfr_cordic_req_t creq;
  sfr_pkg::sfr_cordic_rsp_t crsp;
  logic signed [17:0] op_a;
  logic signed [40:0] op_b;
  logic signed [74:0] prod;

  logic signed [74:0] rnd_i, rnd_a1, rnd_a2, acc_sum, y_full;
  logic signed [39:0] y40;
  logic               go_sweep;
  logic [25:0]        pos_sum;

  sfr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp)
  );

  sfr_mac u_mac (.clk(clk), .op_a(op_a), .op_b(op_b), .prod(prod));

  logic in_fire;
  assign in_tready = (state_r == sfr_pkg::ST_IDLE) && !out_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfr_pkg::ST_IDLE:     if (in_fire) state_nxt = sfr_pkg::ST_LOAD;
      sfr_pkg::ST_LOAD:     state_nxt = sfr_pkg::ST_INTERP;
      sfr_pkg::ST_INTERP:   if (isel_r == 2'd3)
                              state_nxt = upd_r ? sfr_pkg::ST_COS_GO : sfr_pkg::ST_ACC_G;
      sfr_pkg::ST_COS_GO:   state_nxt = sfr_pkg::ST_COS_WAIT;
      sfr_pkg::ST_COS_WAIT: if (crsp.done) state_nxt = sfr_pkg::ST_A1;
      sfr_pkg::ST_A1:       state_nxt = sfr_pkg::ST_A2;
      sfr_pkg::ST_A2:       state_nxt = sfr_pkg::ST_ACC_G;
      sfr_pkg::ST_ACC_G:    state_nxt = sfr_pkg::ST_ACC_1;
      sfr_pkg::ST_ACC_1:    state_nxt = sfr_pkg::ST_ACC_2;
      sfr_pkg::ST_ACC_2:    state_nxt = sfr_pkg::ST_OUT;
      sfr_pkg::ST_OUT:      state_nxt = sfr_pkg::ST_IDLE;
      default:              state_nxt = sfr_pkg::ST_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      sfr_pkg::ST_INTERP: begin
        case (isel_r)
          2'd0:    op_a = d_f_r;
          2'd1:    op_a = d_r_r;
          default: op_a = d_g_r;
        endcase
        // the first product already needs the advanced position
        op_b = $signed({16'd0, (isel_r == 2'd0) ? pos_sum[24:0] : pos_r});
      end
      sfr_pkg::ST_A1: begin
        op_a = $signed({2'b00, cur_r_r});
        op_b = 41'(crsp.cos_val);
      end
      sfr_pkg::ST_A2: begin
        op_a = $signed({2'b00, cur_r_r});
        op_b = $signed({25'd0, cur_r_r});
      end
      sfr_pkg::ST_ACC_G: begin
        op_a = 18'(cur_g_r);
        op_b = 41'(x_r);
      end
      sfr_pkg::ST_ACC_1: begin
        op_a = a1_r;
        op_b = 41'(y1_r);
      end
      sfr_pkg::ST_ACC_2: begin
        op_a = a2_r;
        op_b = 41'(y2_r);
      end
      default: ;
    endcase
    creq.start = (state_r == sfr_pkg::ST_COS_GO);
    creq.freq  = cur_f_r;
  end

  always_comb begin
    rnd_i   = (prod + 75'sd8388608) >>> 24;
    rnd_a1  = (prod + 75'sd268435456) >>> 29;
    rnd_a2  = (prod + 75'sd32768) >>> 16;
    acc_sum = acc_r + prod;
    y_full  = (acc_sum + 75'sd32768) >>> 16;
    if (y_full > 75'sd549755813887)       y40 = 40'sh7FFFFFFFFF;
    else if (y_full < -75'sd549755813888) y40 = 40'sh8000000000;
    else                                  y40 = 40'(y_full);
    go_sweep = active_r && (sweep_rate_r != '0);
    pos_sum  = 26'(pos_r) + 26'(sweep_rate_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfr_pkg::ST_IDLE;
      y1_r        <= '0;
      y2_r        <= '0;
      base_f_r    <= '0;
      base_r_r    <= '0;
      base_g_r    <= $signed(sfr_pkg::GAIN_ONE);
      cur_f_r     <= '0;
      cur_r_r     <= '0;
      cur_g_r     <= $signed(sfr_pkg::GAIN_ONE);
      d_f_r       <= '0;
      d_r_r       <= '0;
      d_g_r       <= '0;
      pos_r       <= '0;
      active_r    <= 1'b0;
      a1_r        <= '0;
      a2_r        <= '0;
      upd_r       <= 1'b0;
      isel_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        sfr_pkg::ST_IDLE: if (in_fire) begin
          x_r <= $signed(in_tdata[SAMPLE_BITS-1:0]);
          upd_r <= 1'b0;
          if (in_tuser[0]) begin
            active_r <= 1'b0;
            base_f_r <= start_freq_r;  cur_f_r <= start_freq_r;
            base_r_r <= start_reson_r; cur_r_r <= start_reson_r;
            base_g_r <= $signed(start_gain_r); cur_g_r <= $signed(start_gain_r);
            upd_r    <= 1'b1;
          end
        end
        sfr_pkg::ST_LOAD: begin
          isel_r <= '0;
          if (in_tuser_hold_r[1]) begin
            base_f_r <= cur_f_r;
            base_r_r <= cur_r_r;
            base_g_r <= cur_g_r;
            d_f_r    <= $signed({2'b00, target_freq_r}) - $signed({2'b00, cur_f_r});
            d_r_r    <= $signed({2'b00, target_reson_r}) - $signed({2'b00, cur_r_r});
            d_g_r    <= 18'($signed(target_gain_r)) - 18'(cur_g_r);
            pos_r    <= '0;
            active_r <= 1'b1;
          end
        end
        sfr_pkg::ST_INTERP: begin
          // isel 0 advances position, 1..3 take products of the deltas
          isel_r <= isel_r + 2'd1;
          case (isel_r)
            2'd0: if (go_sweep) begin
              upd_r <= 1'b1;
              if (pos_sum >= 26'(sfr_pkg::ONE_Q24)) begin
                pos_r    <= sfr_pkg::ONE_Q24;
                active_r <= 1'b0;
                base_f_r <= target_freq_r;  cur_f_r <= target_freq_r;
                base_r_r <= target_reson_r; cur_r_r <= target_reson_r;
                base_g_r <= $signed(target_gain_r); cur_g_r <= $signed(target_gain_r);
                interp_r <= 1'b0;
              end else begin
                pos_r    <= pos_sum[24:0];
                interp_r <= 1'b1;
              end
            end else begin
              interp_r <= 1'b0;
            end
            default: ;
          endcase
        end
        sfr_pkg::ST_A2: begin
          a1_r <= (rnd_a1 > 75'sd131071) ? 18'sd131071 :
                  (rnd_a1 < -75'sd131072) ? -18'sd131072 : 18'(rnd_a1);
        end
        sfr_pkg::ST_ACC_G: if (upd_r) a2_r <= -18'(rnd_a2);
        sfr_pkg::ST_ACC_1: acc_r <= prod <<< 2;
        sfr_pkg::ST_ACC_2: acc_r <= acc_sum;
        sfr_pkg::ST_OUT: begin
          y2_r <= y1_r;
          y1_r <= y40;
          if (y40 > 40'sd2147483647) begin
            out_data_r <= 32'h7FFFFFFF; clip_r <= 1'b1;
          end else if (y40 < -40'sd2147483648) begin
            out_data_r <= 32'h80000000; clip_r <= 1'b1;
          end else begin
            out_data_r <= 32'(y40); clip_r <= 1'b0;
          end
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
      // interpolation products land in the cycle after their operands
      if (state_r == sfr_pkg::ST_INTERP && interp_r) begin
        case (isel_r)
          2'd1: cur_f_r <= 16'(18'(base_f_r) + 18'(rnd_i));
          2'd2: cur_r_r <= 16'(18'(base_r_r) + 18'(rnd_i));
          2'd3: cur_g_r <= 16'(base_g_r + 16'(rnd_i));
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) in_tuser_hold_r <= in_tuser;
  end

  // final accumulate step moved into the output: y uses acc with a2*y2 added
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {active_r, clip_r};

endmodule

/* rtl/sfr_cordic.sv */
// ----------------------------------------------------------------------------
// sfr_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle, cos in Q4.30
// ----------------------------------------------------------------------------
module sfr_cordic #(
  parameter int CORDIC_STEPS = sfr_pkg::CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sfr_pkg::sfr_cordic_req_t req,
  output sfr_pkg::sfr_cordic_rsp_t rsp
);

  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic               neg_r, busy_r, done_r;
  logic [CNT_W-1:0]   step_r;

  logic [15:0]        f_adj;
  logic               f_neg;
  logic signed [33:0] ys, xs, ang;
  logic [4:0]         step_i;

  always_comb begin
    f_neg = (16'(req.freq + 16'd16384)) >= 16'd32768;
    f_adj = f_neg ? (req.freq ^ 16'h8000) : req.freq;
    step_i = 5'(step_r);
    ys  = y_r >>> step_i;
    xs  = x_r >>> step_i;
    ang = $signed({2'b00, sfr_pkg::atan_turn(step_i)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == CNT_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= sfr_pkg::CORDIC_X0;
      y_r   <= '0;
      z_r   <= 34'($signed(f_adj)) <<< 16;
      neg_r <= f_neg;
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - ang;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + ang;
      end
    end
  end

  assign rsp.done    = done_r;
  assign rsp.cos_val = neg_r ? -x_r : x_r;

endmodule

/* rtl/sfr_mac.sv */
// ----------------------------------------------------------------------------
// sfr_mac
// shared 18x41 signed multiplier with registered product
// ----------------------------------------------------------------------------
module sfr_mac (
  input  logic               clk,
  input  logic signed [17:0] op_a,
  input  logic signed [40:0] op_b,
  output logic signed [74:0] prod
);

  logic signed [74:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 75'(op_a * op_b);
  end

  assign prod = prod_r;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept formant resonator testbench
// streams audio beats through the resonator, predicts every result beat with
// an in-bench fixed point filter and sweep model, and compares field by field
// ----------------------------------------------------------------------------
module testbench;

  localparam int  LIMIT = 3000000;
  localparam int  CORDIC_N = 16;
  localparam logic [sfr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [23:0] sample;
    logic        set_start;
    logic        start_sweep;
  } audio_beat_t;

  typedef struct packed {
    logic [31:0] filtered;
    logic        clipped;
    logic        sweeping;
  } filtered_beat_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [23:0] in_tdata;   // sample
  logic [1:0]  in_tuser;   // set_start, start_sweep
  logic [31:0] out_tdata;  // filtered
  logic [1:0]  out_tuser;  // clipped, sweeping
  logic cfg_we;
  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data;

  swept_formant_resonator_top DUT (.*);

  audio_beat_t    pending_beats[$];
  filtered_beat_t expected_beats[$];
  int  err_count = 0;
  int  cycles = 0;
  int  tx_idle_pct = 0, rx_idle_pct = 0, rx_hold = 0;
  bit  in_fire = 0;

  // register copies and resonator state
  logic [15:0] r_sfreq, r_sres, r_tfreq, r_tres;
  logic signed [15:0] r_sgain, r_tgain;
  logic [24:0] r_rate;
  logic signed [39:0] y1, y2;
  logic [15:0] base_freq, base_res, cur_freq, cur_res;
  logic signed [15:0] base_gain, cur_gain;
  logic signed [17:0] d_freq, d_res, d_gain, a1, a2;
  logic [24:0] sweep_pos;
  bit sweep_on;

  longint atan_tab[CORDIC_N] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D};

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint cosine_q30(logic [15:0] f);
    longint x, y, z, t;
    bit neg;
    x = 652032874; y = 0;
    neg = ((f + 16'd16384) & 16'hFFFF) >= 32768;
    if (neg) f = f ^ 16'h8000;
    z = longint'($signed(f)) * 65536;
    for (int i = 0; i < CORDIC_N; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
      end
      x = t;
    end
    return neg ? -x : x;
  endfunction

  function automatic void pole_update();
    longint v;
    v = (longint'(cur_res) * cosine_q30(cur_freq) + (longint'(1) << 28)) >>> 29;
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    a1 = 18'(v);
    a2 = 18'(-((longint'(cur_res) * longint'(cur_res) + 32768) >>> 16));
  endfunction

  function automatic filtered_beat_t resonate(audio_beat_t b);
    filtered_beat_t r;
    longint p, acc, y;
    if (b.set_start) begin
      sweep_on = 0;
      base_freq = r_sfreq; cur_freq = r_sfreq;
      base_res = r_sres;   cur_res = r_sres;
      base_gain = r_sgain; cur_gain = r_sgain;
      pole_update();
    end
    if (b.start_sweep) begin
      base_freq = cur_freq; base_res = cur_res; base_gain = cur_gain;
      d_freq = 18'(longint'(r_tfreq) - longint'(cur_freq));
      d_res  = 18'(longint'(r_tres) - longint'(cur_res));
      d_gain = 18'(longint'(r_tgain) - longint'(cur_gain));
      sweep_pos = '0;
      sweep_on = 1;
    end
    if (sweep_on && r_rate != 0) begin
      p = longint'(sweep_pos) + longint'(r_rate);
      if (p >= (longint'(1) << 24)) begin
        sweep_pos = 25'd16777216;
        sweep_on = 0;
        base_freq = r_tfreq; cur_freq = r_tfreq;
        base_res = r_tres;   cur_res = r_tres;
        base_gain = r_tgain; cur_gain = r_tgain;
      end else begin
        sweep_pos = 25'(p);
        cur_freq = 16'(longint'(base_freq) + ((longint'(d_freq) * p + (1 << 23)) >>> 24));
        cur_res  = 16'(longint'(base_res) + ((longint'(d_res) * p + (1 << 23)) >>> 24));
        cur_gain = 16'(longint'(base_gain) + ((longint'(d_gain) * p + (1 << 23)) >>> 24));
      end
      pole_update();
    end
    acc = longint'(cur_gain) * longint'($signed(b.sample)) * 4
        + longint'(a1) * longint'(y1) + longint'(a2) * longint'(y2);
    y = (acc + 32768) >>> 16;
    if (y > 64'sd549755813887) y = 64'sd549755813887;
    if (y < -64'sd549755813888) y = -64'sd549755813888;
    y2 = y1;
    y1 = 40'(y);
    r.clipped = 0;
    if (y > 64'sd2147483647) begin y = 64'sd2147483647; r.clipped = 1; end
    if (y < -64'sd2147483648) begin y = -64'sd2147483648; r.clipped = 1; end
    r.filtered = 32'(y);
    r.sweeping = sweep_on;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s at cycle %0d: got %0h expected %0h", what, cycles, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // monitor: predict on every accepted input beat, check every output beat
  always @(posedge clk) begin
    filtered_beat_t want;
    audio_beat_t b;
    if (rst_n && in_tvalid && in_tready) begin
      b.sample = in_tdata;
      b.set_start = in_tuser[0];
      b.start_sweep = in_tuser[1];
      expected_beats.push_back(resonate(b));
      in_fire = 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat", out_tdata, 0);
      end else begin
        want = expected_beats.pop_front();
        if (out_tdata !== want.filtered) report("filtered", out_tdata, want.filtered);
        if (out_tuser[0] !== want.clipped) report("clipped", out_tuser[0], want.clipped);
        if (out_tuser[1] !== want.sweeping) report("sweeping", out_tuser[1], want.sweeping);
      end
    end
  end

  // driver
  always @(negedge clk) begin
    audio_beat_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        b = pending_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= b.sample;
        in_tuser <= {b.start_sweep, b.set_start};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_fire = 0;
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic cfg_write(logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                           logic [sfr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      sfr_pkg::REG_START_FREQ:   r_sfreq = val[15:0];
      sfr_pkg::REG_START_RESON:  r_sres = val[15:0];
      sfr_pkg::REG_START_GAIN:   r_sgain = val[15:0];
      sfr_pkg::REG_TARGET_FREQ:  r_tfreq = val[15:0];
      sfr_pkg::REG_TARGET_RESON: r_tres = val[15:0];
      sfr_pkg::REG_TARGET_GAIN:  r_tgain = val[15:0];
      sfr_pkg::REG_SWEEP_RATE:   r_rate = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push(logic [23:0] s, bit st, bit sw);
    audio_beat_t b;
    b.sample = s; b.set_start = st; b.start_sweep = sw;
    pending_beats.push_back(b);
  endtask

  // wait for every result, then let the block settle before touching registers
  task automatic drain();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_tvalid || expected_beats.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16(bit signed_field);
    case ($urandom_range(5))
      0: return signed_field ? 16'h8000 : 16'h0000;
      1: return signed_field ? 16'h7FFF : 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [24:0] pick_rate();
    case ($urandom_range(7))
      0: return 25'd0;
      1: return 25'd16777216;
      2: return 25'($urandom_range(16777216, 8000000));
      3: return 25'($urandom_range(200));
      default: return 25'($urandom_range(2000000, 20000));
    endcase
  endfunction

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      default: return 24'($urandom_range(24'hFFFFFF));
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    r_sfreq = 0; r_sres = 0; r_sgain = sfr_pkg::GAIN_ONE;
    r_tfreq = 0; r_tres = 0; r_tgain = sfr_pkg::GAIN_ONE; r_rate = sfr_pkg::RATE_RESET;
    y1 = 0; y2 = 0; base_freq = 0; base_res = 0; cur_freq = 0; cur_res = 0;
    base_gain = sfr_pkg::GAIN_ONE; cur_gain = sfr_pkg::GAIN_ONE;
    d_freq = 0; d_res = 0; d_gain = 0; a1 = 0; a2 = 0;
    sweep_pos = 0; sweep_on = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values, then an unstable pole pair to drive both saturations
    push(24'h7FFFFF, 1'b0, 1'b0);
    push(24'h800000, 1'b0, 1'b1);
    drain();
    cfg_write(sfr_pkg::REG_START_FREQ, 25'd0);
    cfg_write(sfr_pkg::REG_START_RESON, 25'h00FFFF);
    cfg_write(sfr_pkg::REG_START_GAIN, 25'h007FFF);
    cfg_write(sfr_pkg::REG_TARGET_FREQ, 25'h00FFFF);
    cfg_write(sfr_pkg::REG_TARGET_RESON, 25'd0);
    cfg_write(sfr_pkg::REG_TARGET_GAIN, 25'h008000);
    cfg_write(sfr_pkg::REG_SWEEP_RATE, 25'd16777216);
    cfg_write(REG_UNUSED, 25'h1FFFFFF);
    push(24'h7FFFFF, 1'b1, 1'b0);
    for (int i = 0; i < 12; i++) push(24'h7FFFFF, 1'b0, 1'b0);
    push(24'h800000, 1'b1, 1'b1);   // both flags: load, arm, and finish on one beat
    push(24'h000001, 1'b0, 1'b0);
    drain();
    cfg_write(sfr_pkg::REG_SWEEP_RATE, 25'd0);
    cfg_write(sfr_pkg::REG_START_FREQ, 25'd40000);   // past half rate
    push(24'h123456, 1'b1, 1'b0);
    push(24'h7FFFFF, 1'b0, 1'b1);                    // zero rate keeps the sweep paused
    push(24'h800000, 1'b0, 1'b0);
    drain();
    cfg_write(sfr_pkg::REG_SWEEP_RATE, 25'd6000000);
    push(24'h000100, 1'b0, 1'b0);
    push(24'h7FFFFF, 1'b0, 1'b1);                    // restart midway from current values
    push(24'h800000, 1'b0, 1'b0);
    push(24'h000000, 1'b0, 1'b0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin tx_idle_pct = 12; rx_idle_pct = 53; end
        1: begin tx_idle_pct = 53; rx_idle_pct = 12; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      cfg_write(sfr_pkg::REG_START_FREQ, 25'(pick16(1'b0)));
      cfg_write(sfr_pkg::REG_START_RESON,
                25'($urandom_range(3) == 0 ? pick16(1'b0) : $urandom_range(62000)));
      cfg_write(sfr_pkg::REG_START_GAIN, 25'(pick16(1'b1)));
      cfg_write(sfr_pkg::REG_TARGET_FREQ, 25'(pick16(1'b0)));
      cfg_write(sfr_pkg::REG_TARGET_RESON,
                25'($urandom_range(3) == 0 ? pick16(1'b0) : $urandom_range(62000)));
      cfg_write(sfr_pkg::REG_TARGET_GAIN, 25'(pick16(1'b1)));
      cfg_write(sfr_pkg::REG_SWEEP_RATE, pick_rate());
      if (phase == 1) rx_hold = 400;
      push(pick_sample(), 1'b1, 1'b0);
      for (int i = 0; i < 280; i++) begin
        case ($urandom_range(39))
          0, 1: push(pick_sample(), 1'b0, 1'b1);
          2:    push(pick_sample(), 1'b1, 1'b0);
          3:    push(pick_sample(), 1'b1, 1'b1);
          default: push(pick_sample(), 1'b0, 1'b0);
        endcase
      end
      drain();
    end

    if (expected_beats.size() != 0) report("leftover beats", expected_beats.size(), 0);
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
